// File: design/fol_pkg.sv
// fol_pkg: item types, request and status codes, and cell control structs
// for the frequency ordered list
// no dependencies
package fol_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOCATE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  position;
    logic [15:0] hit_count;
    logic [4:0]  length;
  } rsp_t;

  // control from the top level to every cell
  typedef struct packed {
    logic capture;
    logic commit;
    req_e op;
  } cell_ctl_t;

  // flags that ripple from head toward tail
  typedef struct packed {
    logic ahead;  // a match exists at a lower index
    logic shift;  // at or behind the hit entry
  } lr_t;

endpackage

// File: design/fol_cell.sv
// fol_cell: one list entry, with key and count, its compare and its move logic
// depends on fol_pkg
module fol_cell import fol_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int TOT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IDX_W-1:0]      idx_i,
  input  cell_ctl_t             ctl_i,
  input  logic [31:0]           req_key_i,
  input  logic [COUNT_BITS-1:0] new_cnt_i,
  input  logic [TOT_W-1:0]      total_i,
  input  lr_t                   lr_i,
  output lr_t                   lr_o,
  input  logic [COUNT_BITS-1:0] sel_cnt_i,
  output logic [COUNT_BITS-1:0] sel_cnt_o,
  input  logic [IDX_W-1:0]      pos_i,
  output logic [IDX_W-1:0]      pos_o,
  input  logic                  range_i,
  output logic                  range_o,
  input  logic [31:0]           left_key_i,
  input  logic [COUNT_BITS-1:0] left_cnt_i,
  input  logic [31:0]           right_key_i,
  input  logic [COUNT_BITS-1:0] right_cnt_i,
  output logic [31:0]           key_o,
  output logic [COUNT_BITS-1:0] cnt_o
);

  logic [31:0]           key_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  hit_q;
  logic                  occupied;
  logic                  match;
  logic                  first;
  logic                  in_range;
  logic                  is_dest;
  logic                  sel;
  logic                  at_tail;

  assign occupied = TOT_W'(idx_i) < total_i;
  assign at_tail  = TOT_W'(idx_i) == total_i;
  assign match    = occupied && (key_q == req_key_i);
  assign first    = match && !lr_i.ahead;

  assign lr_o.ahead = lr_i.ahead | match;
  assign lr_o.shift = lr_i.shift | hit_q;
  assign sel_cnt_o  = first ? cnt_q : sel_cnt_i;

  // moving range grows from the hit entry toward the head
  assign in_range = hit_q | (range_i && (new_cnt_i > cnt_q));
  assign range_o  = in_range;
  assign is_dest  = in_range && !(new_cnt_i > left_cnt_i);

  assign sel   = (ctl_i.op == REQ_LOCATE) ? is_dest : hit_q;
  assign pos_o = sel ? idx_i : pos_i;

  assign key_o = key_q;
  assign cnt_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctl_i.capture) begin
      hit_q <= first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      case (ctl_i.op)
        REQ_INSERT: begin
          if (at_tail) begin
            key_q <= req_key_i;
            cnt_q <= '0;
          end
        end
        REQ_DELETE: begin
          if (lr_o.shift) begin
            key_q <= right_key_i;
            cnt_q <= right_cnt_i;
          end
        end
        REQ_LOCATE: begin
          if (is_dest) begin
            key_q <= req_key_i;
            cnt_q <= new_cnt_i;
          end else if (in_range) begin
            key_q <= left_key_i;
            cnt_q <= left_cnt_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/frequency_ordered_list_top.sv
// frequency_ordered_list_top: frequency ordered list built as a chain of cells
// depends on fol_pkg and fol_cell
//
// The block keeps up to DEPTH keys, each with a saturating access count, in
// non-increasing count order from the head. Every item (insert, delete,
// locate or none) gives exactly one result item. At the accepting edge
// every cell compares its key with the request and the first match is
// latched along the cell chain; in the move state the cells shift toward
// the head or the tail in one step and the result is loaded into the
// output register. The move waits while a previous result still sits
// unaccepted in the output register. in_stall_o is high from the accepting
// edge until the move is done, so no new item is taken before the last one
// is through. The compare chain and the shift chain each ripple through all
// DEPTH cells combinationally.
module frequency_ordered_list_top import fol_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int TOT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_MOVE
  } state_e;

  state_e                state_q;
  req_t                  req_q;
  logic                  found_q;
  logic [COUNT_BITS-1:0] old_cnt_q;
  logic [TOT_W-1:0]      total_q;
  logic                  out_valid_q;
  rsp_t                  out_data_q;

  logic                  accept;
  logic                  commit;
  logic                  full;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [31:0]           req_key;
  cell_ctl_t             ctl;
  rsp_t                  rsp_d;
  logic [TOT_W-1:0]      total_d;

  // chains between cells: index k feeds cell k from the head side, but rng runs from the tail (rng[k+1] feeds cell k)
  lr_t                   lr   [DEPTH+1];
  logic [COUNT_BITS-1:0] scnt [DEPTH+1];
  logic [IDX_W-1:0]      pos  [DEPTH+1];
  logic                  rng  [DEPTH+1];
  logic [31:0]           keys [DEPTH];
  logic [COUNT_BITS-1:0] cnts [DEPTH];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  // the move waits until the output register is free
  assign commit     = (state_q == S_MOVE) && (!out_valid_q || !out_stall_i);

  assign full    = (total_q == TOT_W'(DEPTH));
  assign new_cnt = (old_cnt_q == '1) ? old_cnt_q : old_cnt_q + COUNT_BITS'(1);
  // cells compare against the incoming key, then work from the held one
  assign req_key = (state_q == S_IDLE) ? in_data_i.key : req_q.key;

  assign ctl.capture = accept;
  assign ctl.commit  = commit;
  assign ctl.op      = req_e'(req_q.req_type);

  assign lr[0]      = '0;
  assign scnt[0]    = '0;
  assign pos[0]     = '0;
  assign rng[DEPTH] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [31:0]           left_key;
    logic [COUNT_BITS-1:0] left_cnt;
    logic [31:0]           right_key;
    logic [COUNT_BITS-1:0] right_cnt;

    if (k == 0) begin : g_head
      // nothing ahead of the head: its count counts as maximal
      assign left_key = '0;
      assign left_cnt = '1;
    end else begin : g_mid
      assign left_key = keys[k-1];
      assign left_cnt = cnts[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_key = keys[k];
      assign right_cnt = cnts[k];
    end else begin : g_body
      assign right_key = keys[k+1];
      assign right_cnt = cnts[k+1];
    end

    fol_cell #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(k)),
      .ctl_i       (ctl),
      .req_key_i   (req_key),
      .new_cnt_i   (new_cnt),
      .total_i     (total_q),
      .lr_i        (lr[k]),
      .lr_o        (lr[k+1]),
      .sel_cnt_i   (scnt[k]),
      .sel_cnt_o   (scnt[k+1]),
      .pos_i       (pos[k]),
      .pos_o       (pos[k+1]),
      .range_i     (rng[k+1]),
      .range_o     (rng[k]),
      .left_key_i  (left_key),
      .left_cnt_i  (left_cnt),
      .right_key_i (right_key),
      .right_cnt_i (right_cnt),
      .key_o       (keys[k]),
      .cnt_o       (cnts[k])
    );
  end

  // result and new length of the item under way
  always_comb begin
    rsp_d           = '0;
    rsp_d.status    = ST_MISS;
    rsp_d.length    = 5'(total_q);
    total_d         = total_q;
    case (req_e'(req_q.req_type))
      REQ_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          total_d        = total_q + TOT_W'(1);
          rsp_d.status   = ST_DONE;
          rsp_d.position = 4'(total_q);
          rsp_d.length   = 5'(total_d);
        end
      end
      REQ_DELETE: begin
        if (found_q) begin
          total_d         = total_q - TOT_W'(1);
          rsp_d.status    = ST_DONE;
          rsp_d.position  = 4'(pos[DEPTH]);
          rsp_d.hit_count = 16'(old_cnt_q);
          rsp_d.length    = 5'(total_d);
        end
      end
      REQ_LOCATE: begin
        if (found_q) begin
          rsp_d.status    = ST_DONE;
          rsp_d.position  = 4'(pos[DEPTH]);
          rsp_d.hit_count = 16'(new_cnt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      req_q       <= '0;
      old_cnt_q   <= '0;
      out_data_q  <= '0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q     <= in_data_i;
            found_q   <= lr[DEPTH].ahead;
            old_cnt_q <= scnt[DEPTH];
            state_q   <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (commit) begin
            total_q    <= total_d;
            out_data_q <= rsp_d;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/fol_checker.sv
// fol_checker: port-level checks on the frequency ordered list, bound to the top
// depends on fol_pkg and frequency_ordered_list_top
module fol_checker import fol_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  // a result waiting on a stall stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted item leaves the input stalled after the accepting edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous still in work");

  // failed operations report no position and no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_DONE) |->
      (out_data_o.position == 4'd0) && (out_data_o.hit_count == 16'd0))
    else $error("failed result carries position or count");

  // list length never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.length) <= 32'(DEPTH)))
    else $error("length beyond capacity");

endmodule

bind frequency_ordered_list_top fol_checker #(.DEPTH(DEPTH)) u_fol_checker (.*);

// File: verif/frequency_ordered_list_top_test.sv
// frequency_ordered_list_top_test: self-checking bench for the frequency ordered list
// depends on fol_pkg and frequency_ordered_list_top
// drives insert, delete and locate items and checks every result item against a shadow list
module frequency_ordered_list_top_test;
  import fol_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam int IDLE_PCT    = 32;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1000;
  // about 1050 items; the limit leaves a wide margin for both sides idling
  // and the two hold-offs
  localparam int CYCLE_LIMIT = 60000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;

  frequency_ordered_list_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // items still to be offered, and result items owed by the block in order
  req_t req_backlog[$];
  rsp_t rsp_due[$];

  // shadow copy of the list: keys, access counts and current length
  logic [31:0] list_keys [LIST_DEPTH];
  logic [15:0] list_counts [LIST_DEPTH];
  int          list_len;

  int   fault_count;
  int   items_taken;
  int   results_seen;
  int   cycle_count;
  int   hold_left;
  int   hold_mark_a;
  int   hold_mark_b;
  int   calm_lo;
  int   calm_hi;
  logic offer_live;
  rsp_t want_rsp;

  // apply one request to the shadow list and return the result item it gives
  function automatic rsp_t list_update(input req_t r);
    rsp_t        res;
    int          hit;
    int          dst;
    int          idx;
    logic [15:0] cnt;
    res = '0;
    hit = -1;
    for (idx = 0; idx < list_len; idx++) begin
      if (hit < 0 && list_keys[idx] == r.key) hit = idx;
    end
    case (req_e'(r.req_type))
      REQ_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_keys[list_len]   = r.key;
          list_counts[list_len] = '0;
          res.status   = ST_DONE;
          res.position = list_len[3:0];
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          res.status    = ST_DONE;
          res.position  = hit[3:0];
          res.hit_count = list_counts[hit];
          // close the gap toward the head
          for (idx = hit; idx + 1 < list_len; idx++) begin
            list_keys[idx]   = list_keys[idx + 1];
            list_counts[idx] = list_counts[idx + 1];
          end
          list_len--;
        end
      end
      REQ_LOCATE: begin
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          cnt = list_counts[hit];
          if (cnt != COUNT_TOP) cnt++;
          // move ahead of every entry with a strictly smaller count
          dst = hit;
          while (dst > 0 && cnt > list_counts[dst - 1]) dst--;
          for (idx = hit; idx > dst; idx--) begin
            list_keys[idx]   = list_keys[idx - 1];
            list_counts[idx] = list_counts[idx - 1];
          end
          list_keys[dst]   = r.key;
          list_counts[dst] = cnt;
          res.status    = ST_DONE;
          res.position  = dst[3:0];
          res.hit_count = cnt;
        end
      end
      default: begin
        res.status = ST_MISS;
      end
    endcase
    res.length = list_len[4:0];
    return res;
  endfunction

  task automatic add_item(input req_e op, input logic [31:0] key);
    req_t r;
    r.req_type = op;
    r.key      = key;
    req_backlog.push_back(r);
  endtask

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // global cycle budget: a hang or lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frequency_ordered_list_top regression: fail");
      $finish;
    end
  end

  // sender: offers the head of the backlog at the falling edge and keeps it
  // steady until taken; no idling inside the calm window or while the
  // receiver holds off, so the block fills up and stalls its input
  always @(negedge clk_i) begin
    if (rst_ni && !offer_live) begin
      if (req_backlog.size() > 0 &&
          ((items_taken >= calm_lo && items_taken < calm_hi) || hold_left > 0 ||
           $urandom_range(99) >= IDLE_PCT)) begin
        in_data_i  <= req_backlog[0];
        in_valid_i <= 1'b1;
        offer_live = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // input side: every accepted item updates the shadow list right away,
  // which matches the block since items are handled strictly in order
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rsp_due.push_back(list_update(in_data_i));
      void'(req_backlog.pop_front());
      offer_live = 1'b0;
      items_taken++;
    end
  end

  // receiver: random stall, none in the calm window, solid during a hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !(results_seen >= calm_lo && results_seen < calm_hi) &&
                     ($urandom_range(99) < IDLE_PCT);
    end
  end

  // output side: compare each accepted result item with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_due.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result %0d: status %0d position %0d count %0d length %0d",
                   results_seen, out_data_o.status, out_data_o.position,
                   out_data_o.hit_count, out_data_o.length);
        fault_count++;
      end else begin
        want_rsp = rsp_due.pop_front();
        if (out_data_o.status !== want_rsp.status ||
            out_data_o.position !== want_rsp.position ||
            out_data_o.hit_count !== want_rsp.hit_count ||
            out_data_o.length !== want_rsp.length) begin
          if (fault_count < 10)
            $display({"result %0d mismatch: expected status %0d position %0d count %0d ",
                      "length %0d, got status %0d position %0d count %0d length %0d"},
                     results_seen, want_rsp.status, want_rsp.position,
                     want_rsp.hit_count, want_rsp.length, out_data_o.status,
                     out_data_o.position, out_data_o.hit_count, out_data_o.length);
          fault_count++;
        end
      end
      results_seen++;
      // long hold-off starts right after a chosen result
      if (results_seen == hold_mark_a || results_seen == hold_mark_b)
        hold_left = HOLD_CYCLES;
    end
  end

  initial begin
    int          k;
    int          n;
    int          pick;
    int          ins_pct;
    int          del_pct;
    logic [31:0] key_pool [20];
    logic [31:0] sat_a;
    logic [31:0] sat_b;
    logic [31:0] sat_c;
    logic [31:0] key;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    offer_live   = 1'b0;
    list_len     = 0;
    fault_count  = 0;
    items_taken  = 0;
    results_seen = 0;
    cycle_count  = 0;
    hold_left    = 0;
    for (k = 0; k < LIST_DEPTH; k++) begin
      list_keys[k]   = '0;
      list_counts[k] = '0;
    end

    // empty list: misses on delete and locate, and the unused request code
    add_item(REQ_LOCATE, 32'h1234_5678);
    add_item(REQ_DELETE, 32'h0000_0000);
    add_item(REQ_NONE, 32'hFFFF_FFFF);
    // key extremes, with a duplicate to check first-match behavior
    add_item(REQ_INSERT, 32'h8000_0000);
    add_item(REQ_INSERT, 32'h7FFF_FFFF);
    add_item(REQ_INSERT, 32'h0000_0000);
    add_item(REQ_INSERT, 32'hFFFF_FFFF);
    add_item(REQ_INSERT, 32'h7FFF_FFFF);
    add_item(REQ_LOCATE, 32'h7FFF_FFFF);
    add_item(REQ_LOCATE, 32'h7FFF_FFFF);
    add_item(REQ_LOCATE, 32'hFFFF_FFFF);
    add_item(REQ_LOCATE, 32'h8000_0000);
    add_item(REQ_DELETE, 32'hDEAD_BEEF);
    add_item(REQ_LOCATE, 32'h0000_0001);
    add_item(REQ_DELETE, 32'h0000_0000);
    add_item(REQ_NONE, 32'h5555_AAAA);
    // fill to the top; the last insert hits a full list
    for (k = 0; k < 13; k++) add_item(REQ_INSERT, 32'hA500_0000 + k);
    add_item(REQ_DELETE, 32'hFFFF_FFFF);
    add_item(REQ_DELETE, 32'hA500_000B);
    add_item(REQ_DELETE, 32'h7FFF_FFFF);
    add_item(REQ_DELETE, 32'h7FFF_FFFF);

    // equal counts: a key that catches up with the one ahead stops behind it
    sat_a = 32'h5A5A_0001;
    sat_b = 32'h5A5A_0002;
    sat_c = 32'h5A5A_0003;
    hold_mark_a = req_backlog.size() + 5;
    add_item(REQ_INSERT, sat_a);
    add_item(REQ_INSERT, sat_c);
    add_item(REQ_INSERT, sat_b);
    for (k = 0; k < 3; k++) add_item(REQ_LOCATE, sat_a);
    add_item(REQ_LOCATE, sat_c);
    for (k = 0; k < 3; k++) add_item(REQ_LOCATE, sat_b);
    add_item(REQ_LOCATE, sat_a);
    add_item(REQ_DELETE, sat_a);
    add_item(REQ_DELETE, sat_b);
    add_item(REQ_DELETE, sat_c);

    // random traffic: keys mostly from a small pool so that deletes and
    // locates usually hit; the insert share shifts so the list both drains
    // and runs full
    hold_mark_b = req_backlog.size() + 150;
    calm_lo     = req_backlog.size() + 400;
    calm_hi     = req_backlog.size() + 650;
    for (k = 0; k < 20; k++) key_pool[k] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        for (k = 2; k < 6; k++) key_pool[$urandom_range(19)] = $urandom;
        case ((n / 100) % 3)
          0: begin ins_pct = 50; del_pct = 15; end
          1: begin ins_pct = 30; del_pct = 20; end
          default: begin ins_pct = 15; del_pct = 40; end
        endcase
      end
      key  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(19)];
      pick = $urandom_range(99);
      if (pick < ins_pct) add_item(REQ_INSERT, key);
      else if (pick < ins_pct + del_pct) add_item(REQ_DELETE, key);
      else if (pick < 97) add_item(REQ_LOCATE, key);
      else add_item(REQ_NONE, key);
    end

    // hold reset, then release it away from the sampling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: everything offered and every owed result back, then let the
    // output register settle
    while (req_backlog.size() != 0 || rsp_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("frequency_ordered_list_top regression: pass");
    end else begin
      $display("frequency_ordered_list_top regression: fail");
    end
    $finish;
  end

endmodule
